// ===== rtl/cts_pkg.sv =====
// Shared types, constants and character helpers for the C subset token scanner.
// Used by every module in this folder; depends on nothing else.
package cts_pkg;

    localparam int POS_WIDTH_DEF = 32;
    localparam int LEN_WIDTH_DEF = 16;

    // Token queue between the scan logic and the output port.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    localparam int NUM_KW     = 12;
    localparam int DATA_OUT_W = 56;

    // Token kinds.
    localparam logic [5:0] KIND_EOF     = 6'd0;
    localparam logic [5:0] KIND_IDENT   = 6'd1;
    localparam logic [5:0] KIND_NUMBER  = 6'd2;
    localparam logic [5:0] KIND_KW0     = 6'd3;
    localparam logic [5:0] KIND_LPAREN  = 6'd15;
    localparam logic [5:0] KIND_RPAREN  = 6'd16;
    localparam logic [5:0] KIND_LBRACE  = 6'd17;
    localparam logic [5:0] KIND_RBRACE  = 6'd18;
    localparam logic [5:0] KIND_SEMI    = 6'd19;
    localparam logic [5:0] KIND_COMMA   = 6'd20;
    localparam logic [5:0] KIND_PLUS    = 6'd21;
    localparam logic [5:0] KIND_MINUS   = 6'd22;
    localparam logic [5:0] KIND_STAR    = 6'd23;
    localparam logic [5:0] KIND_SLASH   = 6'd24;
    localparam logic [5:0] KIND_ASSIGN  = 6'd25;
    localparam logic [5:0] KIND_EQ      = 6'd26;
    localparam logic [5:0] KIND_NE      = 6'd27;
    localparam logic [5:0] KIND_LT      = 6'd28;
    localparam logic [5:0] KIND_LE      = 6'd29;
    localparam logic [5:0] KIND_GT      = 6'd30;
    localparam logic [5:0] KIND_GE      = 6'd31;
    localparam logic [5:0] KIND_UNKNOWN = 6'd32;

    // Characters with a role of their own.
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_US   = 8'h5F;

    // Keyword spelling, one row per keyword, padded with zero bytes.
    localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
        '{"i", "n", "t", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
        '{"r", "e", "t", "u", "r", "n", 8'h0, 8'h0},
        '{"i", "f", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
        '{"e", "l", "s", "e", 8'h0, 8'h0, 8'h0, 8'h0},
        '{"w", "h", "i", "l", "e", 8'h0, 8'h0, 8'h0},
        '{"f", "o", "r", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
        '{"c", "o", "n", "t", "i", "n", "u", "e"},
        '{"b", "r", "e", "a", "k", 8'h0, 8'h0, 8'h0},
        '{"s", "w", "i", "t", "c", "h", 8'h0, 8'h0},
        '{"c", "a", "s", "e", 8'h0, 8'h0, 8'h0, 8'h0},
        '{"d", "e", "f", "a", "u", "l", "t", 8'h0},
        '{"s", "t", "r", "u", "c", "t", 8'h0, 8'h0}
    };
    localparam logic [3:0] KW_SIZE [NUM_KW] = '{
        4'd3, 4'd6, 4'd2, 4'd4, 4'd5, 4'd3, 4'd8, 4'd5, 4'd6, 4'd4, 4'd7, 4'd6
    };

    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] start;
        logic [15:0] length;
        logic        last;
    } t_token;

    // Tokens produced by one accepted word, oldest in tok0.
    typedef struct packed {
        logic [1:0] cnt;
        t_token     tok0;
        t_token     tok1;
    } t_push;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_US;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] k;
        unique case (c)
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            ";":     k = KIND_SEMI;
            ",":     k = KIND_COMMA;
            "+":     k = KIND_PLUS;
            "-":     k = KIND_MINUS;
            "*":     k = KIND_STAR;
            "/":     k = KIND_SLASH;
            default: k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    // Keeps the keywords that still match when character c sits at index idx.
    function automatic logic [NUM_KW-1:0] kw_filter(input logic [NUM_KW-1:0] mask,
                                                    input logic idx_ok,
                                                    input logic [2:0] idx,
                                                    input logic [7:0] c);
        logic [NUM_KW-1:0] r;
        r = '0;
        for (int k = 0; k < NUM_KW; k++) begin
            if (mask[k] && idx_ok && ({1'b0, idx} < KW_SIZE[k]) && KW_TEXT[k][idx] == c) begin
                r[k] = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/cts_lexer.sv =====
// Scan state and per-word token logic of the C subset token scanner.
// Depends on cts_pkg for character classes, keyword tables and token types.
module cts_lexer #(
    parameter int POS_WIDTH = cts_pkg::POS_WIDTH_DEF,
    parameter int LEN_WIDTH = cts_pkg::LEN_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_byte,
    output cts_pkg::t_push o_push
);

    localparam logic [2:0] M_IDLE   = 3'd0;
    localparam logic [2:0] M_IDENT  = 3'd1;
    localparam logic [2:0] M_NUMBER = 3'd2;
    localparam logic [2:0] M_EQ     = 3'd3;
    localparam logic [2:0] M_BANG   = 3'd4;
    localparam logic [2:0] M_LT     = 3'd5;
    localparam logic [2:0] M_GT     = 3'd6;

    logic [2:0]                   r_mode,   n_mode;
    logic [POS_WIDTH-1:0]         r_pos,    n_pos;
    logic [POS_WIDTH-1:0]         r_pstart, n_pstart;
    logic [LEN_WIDTH-1:0]         r_plen,   n_plen;
    logic [cts_pkg::NUM_KW-1:0]   r_kw,     n_kw;

    cts_pkg::t_token tok_a, tok_b;
    logic            a_v, b_v, consumed;
    logic            is_l, is_d;
    logic [5:0]      kind_id;
    logic [LEN_WIDTH-1:0] plen_inc;

    always_comb begin
        is_l     = cts_pkg::is_letter(i_byte);
        is_d     = cts_pkg::is_digit(i_byte);
        plen_inc = (r_plen == '1) ? r_plen : r_plen + LEN_WIDTH'(1);

        // The first surviving keyword of matching length names the identifier.
        kind_id = cts_pkg::KIND_IDENT;
        for (int k = cts_pkg::NUM_KW - 1; k >= 0; k--) begin
            if (r_kw[k] && r_plen == LEN_WIDTH'(cts_pkg::KW_SIZE[k])) begin
                kind_id = cts_pkg::KIND_KW0 + 6'(k);
            end
        end

        n_mode   = r_mode;
        n_pstart = r_pstart;
        n_plen   = r_plen;
        n_kw     = r_kw;
        n_pos    = (i_byte == cts_pkg::CH_NUL) ? '0 : r_pos + POS_WIDTH'(1);
        a_v      = 1'b0;
        b_v      = 1'b0;
        consumed = 1'b0;
        tok_a    = '0;
        tok_b    = '0;

        // Close or extend the pending token.
        unique case (r_mode)
            M_IDENT: begin
                if (is_l || is_d) begin
                    n_kw     = cts_pkg::kw_filter(r_kw, r_plen < LEN_WIDTH'(8), r_plen[2:0],
                                                  i_byte);
                    n_plen   = plen_inc;
                    consumed = 1'b1;
                end else begin
                    a_v          = 1'b1;
                    tok_a.kind   = kind_id;
                    tok_a.start  = 32'(r_pstart);
                    tok_a.length = 16'(r_plen);
                end
            end
            M_NUMBER: begin
                if (is_d) begin
                    n_plen   = plen_inc;
                    consumed = 1'b1;
                end else begin
                    a_v          = 1'b1;
                    tok_a.kind   = cts_pkg::KIND_NUMBER;
                    tok_a.start  = 32'(r_pstart);
                    tok_a.length = 16'(r_plen);
                end
            end
            M_EQ, M_BANG, M_LT, M_GT: begin
                a_v         = 1'b1;
                tok_a.start = 32'(r_pstart);
                if (i_byte == cts_pkg::CH_EQ) begin
                    consumed     = 1'b1;
                    n_mode       = M_IDLE;
                    n_kw         = '1;
                    tok_a.length = 16'd2;
                    unique case (r_mode)
                        M_EQ:    tok_a.kind = cts_pkg::KIND_EQ;
                        M_BANG:  tok_a.kind = cts_pkg::KIND_NE;
                        M_LT:    tok_a.kind = cts_pkg::KIND_LE;
                        default: tok_a.kind = cts_pkg::KIND_GE;
                    endcase
                end else begin
                    tok_a.length = 16'd1;
                    unique case (r_mode)
                        M_EQ:    tok_a.kind = cts_pkg::KIND_ASSIGN;
                        M_BANG:  tok_a.kind = cts_pkg::KIND_UNKNOWN;
                        M_LT:    tok_a.kind = cts_pkg::KIND_LT;
                        default: tok_a.kind = cts_pkg::KIND_GT;
                    endcase
                end
            end
            default: ;
        endcase

        // A word that did not extend the pending token is lexed on its own.
        if (!consumed) begin
            n_mode = M_IDLE;
            n_kw   = '1;
            priority if (i_byte == cts_pkg::CH_NUL) begin
                b_v          = 1'b1;
                tok_b.kind   = cts_pkg::KIND_EOF;
                tok_b.start  = 32'(r_pos);
                tok_b.length = 16'd0;
            end else if (cts_pkg::is_blank(i_byte)) begin
                n_mode = M_IDLE;
            end else if (is_l) begin
                n_mode   = M_IDENT;
                n_pstart = r_pos;
                n_plen   = LEN_WIDTH'(1);
                n_kw     = cts_pkg::kw_filter('1, 1'b1, 3'd0, i_byte);
            end else if (is_d) begin
                n_mode   = M_NUMBER;
                n_pstart = r_pos;
                n_plen   = LEN_WIDTH'(1);
            end else if (i_byte == cts_pkg::CH_EQ || i_byte == cts_pkg::CH_BANG ||
                         i_byte == cts_pkg::CH_LT || i_byte == cts_pkg::CH_GT) begin
                n_mode   = (i_byte == cts_pkg::CH_EQ)   ? M_EQ   :
                           (i_byte == cts_pkg::CH_BANG) ? M_BANG :
                           (i_byte == cts_pkg::CH_LT)   ? M_LT   : M_GT;
                n_pstart = r_pos;
                n_plen   = LEN_WIDTH'(1);
            end else begin
                b_v          = 1'b1;
                tok_b.kind   = cts_pkg::single_kind(i_byte);
                tok_b.start  = 32'(r_pos);
                tok_b.length = 16'd1;
            end
        end

        tok_a.last = !b_v;
        tok_b.last = 1'b1;

        o_push.cnt  = i_valid ? ({1'b0, a_v} + {1'b0, b_v}) : 2'd0;
        o_push.tok0 = a_v ? tok_a : tok_b;
        o_push.tok1 = tok_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_pos    <= '0;
            r_pstart <= '0;
            r_plen   <= '0;
            r_kw     <= '1;
        end else if (i_valid) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_pstart <= n_pstart;
            r_plen   <= n_plen;
            r_kw     <= n_kw;
        end
    end

endmodule

// ===== rtl/cts_token_fifo.sv =====
// Small token queue that takes up to two tokens and gives one per cycle while the receiver is ready.
// Depends on cts_pkg for the token types and the queue depth.
module cts_token_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cts_pkg::t_push  i_push,
    output logic            o_room,
    output logic            o_valid,
    input  logic            i_ready,
    output cts_pkg::t_token o_token
);

    cts_pkg::t_token r_mem [cts_pkg::FIFO_DEPTH];

    logic [cts_pkg::FIFO_AW-1:0] r_wp, n_wp;
    logic [cts_pkg::FIFO_AW-1:0] r_rp, n_rp;
    logic [cts_pkg::FIFO_CW-1:0] r_cnt, n_cnt;
    logic                        pop;

    always_comb begin
        pop     = o_valid && i_ready;
        n_wp    = r_wp + cts_pkg::FIFO_AW'(i_push.cnt);
        n_rp    = r_rp + cts_pkg::FIFO_AW'(pop);
        n_cnt   = r_cnt + cts_pkg::FIFO_CW'(i_push.cnt) - cts_pkg::FIFO_CW'(pop);
        // Room for the worst case of two tokens from the next word.
        o_room  = r_cnt <= cts_pkg::FIFO_CW'(cts_pkg::FIFO_DEPTH - 2);
        o_valid = r_cnt != '0;
        o_token = r_mem[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.tok0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wp + cts_pkg::FIFO_AW'(1)] <= i_push.tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/c_subset_token_scanner_core.sv =====
// A token is written into the registered token queue by the word that completes it.
// Throughput: one word per cycle; a word can give two tokens, so the input stalls
// only when the four-entry token queue lacks room for two more.
// Reset (synchronous, active low) clears the scan state, the position and the queue.
// Top level of the C subset token scanner; depends on cts_pkg, cts_lexer and
// cts_token_fifo.
module c_subset_token_scanner_core #(
    parameter int POS_WIDTH = cts_pkg::POS_WIDTH_DEF,
    parameter int LEN_WIDTH = cts_pkg::LEN_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] char_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,   // [5:0] token_kind, [37:6] token_start,
                                          // [53:38] token_length, [55:54] zero
    output logic        o_m_axis_tlast    // last_of_run
);

    cts_pkg::t_push  push;
    cts_pkg::t_token head;
    logic            room;

    cts_lexer #(
        .POS_WIDTH (POS_WIDTH),
        .LEN_WIDTH (LEN_WIDTH)
    ) u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid && room),
        .i_byte  (i_s_axis_tdata),
        .o_push  (push)
    );

    cts_token_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_token (head)
    );

    assign o_s_axis_tready = room;
    assign o_m_axis_tdata  = {2'b00, head.length, head.start, head.kind};
    assign o_m_axis_tlast  = head.last;

endmodule

// ===== rtl/cts_checker.sv =====
// Port-level checks for the C subset token scanner, bound to its top level.
// Depends on cts_pkg for the token kind codes.
module cts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [55:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    // Reset empties the token queue.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output word valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled output word changed");

    // The end-of-text token has zero length and always closes its run.
    a_eof_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[5:0] == cts_pkg::KIND_EOF |->
            o_m_axis_tdata[53:38] == 16'd0 && o_m_axis_tlast)
        else $error("malformed end-of-text token");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[5:0] <= cts_pkg::KIND_UNKNOWN &&
            o_m_axis_tdata[55:54] == 2'b00)
        else $error("token kind out of range");

    // Every lexeme other than end of text holds at least one byte.
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[53:38] == 16'd0 |->
            o_m_axis_tdata[5:0] == cts_pkg::KIND_EOF)
        else $error("empty lexeme on a token other than end of text");

endmodule

bind c_subset_token_scanner_core cts_checker u_cts_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// ===== tb/c_subset_token_scanner_core_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the C subset token scanner: drives source text one
// byte per word and checks every token against a predictor or a directed row's
// expected token. Depends on cts_pkg and c_subset_token_scanner_core.
module c_subset_token_scanner_core_test;

    typedef enum logic [2:0] {
        MODE_IDLE, MODE_IDENT, MODE_NUMBER, MODE_EQ, MODE_BANG, MODE_LT, MODE_GT
    } t_scan_mode;

    // One directed word; a typed row carries the single token it must give.
    typedef struct packed {
        logic [7:0]  ch;
        logic        typed;
        logic [5:0]  kind;
        logic [31:0] start;
        logic [15:0] len;
    } t_row;

    localparam int NUM_ROWS      = 26;
    localparam int RANDOM_BYTES  = 1170;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 8'h00;    // [7:0] char_byte
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [55:0] o_m_axis_tdata;            // [5:0] kind, [37:6] start, [53:38] length
    logic        o_m_axis_tlast;            // last_of_run

    // Predictor state.
    t_scan_mode  mode_q;
    logic [31:0] pos_q;
    logic [31:0] lex_start_q;
    logic [15:0] lex_len_q;
    logic [11:0] kw_live_q;

    cts_pkg::t_token scan_out [$];
    cts_pkg::t_token tokens_due [$];

    int          fail_count = 0;
    int          bytes_sent = 0;
    int          tokens_checked = 0;
    int          longest_lexeme = 0;
    logic [32:0] kinds_seen = '0;
    int          burst_left = 0;
    bit          valid_up = 1'b0;
    bit          hold_req = 1'b0;

    string op_text [18] = '{"(", ")", "{", "}", ";", ",", "+", "-", "*", "/",
                            "=", "==", "!", "!=", "<", "<=", ">", ">="};

    t_row dir_rows [NUM_ROWS] = '{
        '{8'h00, 1'b1, cts_pkg::KIND_EOF,     32'd0,  16'd0},
        '{8'hFF, 1'b1, cts_pkg::KIND_UNKNOWN, 32'd0,  16'd1},
        '{"!",   1'b0, cts_pkg::KIND_EOF,     32'd0,  16'd0},
        '{"x",   1'b0, cts_pkg::KIND_EOF,     32'd0,  16'd0},
        '{"=",   1'b0, cts_pkg::KIND_EOF,     32'd0,  16'd0},
        '{"=",   1'b1, cts_pkg::KIND_EQ,      32'd3,  16'd2},
        '{"<",   1'b0, cts_pkg::KIND_EOF,     32'd0,  16'd0},
        '{"=",   1'b1, cts_pkg::KIND_LE,      32'd5,  16'd2},
        '{">",   1'b0, cts_pkg::KIND_EOF,     32'd0,  16'd0},
        '{8'h09, 1'b1, cts_pkg::KIND_GT,      32'd7,  16'd1},
        '{"!",   1'b0, cts_pkg::KIND_EOF,     32'd0,  16'd0},
        '{"=",   1'b1, cts_pkg::KIND_NE,      32'd9,  16'd2},
        '{"i",   1'b0, cts_pkg::KIND_EOF,     32'd0,  16'd0},
        '{"n",   1'b0, cts_pkg::KIND_EOF,     32'd0,  16'd0},
        '{"t",   1'b0, cts_pkg::KIND_EOF,     32'd0,  16'd0},
        '{8'h0D, 1'b0, cts_pkg::KIND_EOF,     32'd0,  16'd0},
        '{"9",   1'b0, cts_pkg::KIND_EOF,     32'd0,  16'd0},
        '{"(",   1'b0, cts_pkg::KIND_EOF,     32'd0,  16'd0},
        '{"_",   1'b0, cts_pkg::KIND_EOF,     32'd0,  16'd0},
        '{"Z",   1'b0, cts_pkg::KIND_EOF,     32'd0,  16'd0},
        '{"0",   1'b0, cts_pkg::KIND_EOF,     32'd0,  16'd0},
        '{8'h7F, 1'b0, cts_pkg::KIND_EOF,     32'd0,  16'd0},
        '{"=",   1'b0, cts_pkg::KIND_EOF,     32'd0,  16'd0},
        '{8'h00, 1'b0, cts_pkg::KIND_EOF,     32'd0,  16'd0},
        '{">",   1'b0, cts_pkg::KIND_EOF,     32'd0,  16'd0},
        '{8'h00, 1'b0, cts_pkg::KIND_EOF,     32'd0,  16'd0}
    };

    c_subset_token_scanner_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic ident_head(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == cts_pkg::CH_US;
    endfunction

    function automatic logic decimal(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic white(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // Keywords that still match with character c at index idx of the lexeme.
    function automatic logic [11:0] narrow_keywords(input logic [11:0] live,
                                                    input logic [15:0] idx,
                                                    input logic [7:0] c);
        logic [11:0] r;
        r = '0;
        for (int k = 0; k < cts_pkg::NUM_KW; k++) begin
            if (live[k] && idx < 16'(cts_pkg::KW_SIZE[k]) &&
                cts_pkg::KW_TEXT[k][idx[2:0]] == c) begin
                r[k] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic void put_token(input logic [5:0] kind, input logic [31:0] at,
                                      input logic [15:0] len);
        scan_out.push_back('{kind: kind, start: at, length: len, last: 1'b0});
    endfunction

    function automatic void reset_scanner();
        mode_q = MODE_IDLE;
        pos_q = '0;
        lex_start_q = '0;
        lex_len_q = '0;
        kw_live_q = '1;
    endfunction

    // Advances the predictor by one source byte and leaves its tokens in scan_out.
    function automatic void scan_byte(input logic [7:0] c);
        logic [31:0]     here;
        logic            done;
        logic [5:0]      kind;
        cts_pkg::t_token tail;
        here = pos_q;
        done = 1'b0;
        scan_out.delete();
        case (mode_q)
            MODE_IDENT: begin
                if (ident_head(c) || decimal(c)) begin
                    kw_live_q = narrow_keywords(kw_live_q, lex_len_q, c);
                    if (lex_len_q != '1) lex_len_q++;
                    pos_q = here + 1;
                    done = 1'b1;
                end else begin
                    kind = cts_pkg::KIND_IDENT;
                    for (int k = cts_pkg::NUM_KW - 1; k >= 0; k--) begin
                        if (kw_live_q[k] && lex_len_q == 16'(cts_pkg::KW_SIZE[k])) begin
                            kind = cts_pkg::KIND_KW0 + 6'(k);
                        end
                    end
                    put_token(kind, lex_start_q, lex_len_q);
                end
            end
            MODE_NUMBER: begin
                if (decimal(c)) begin
                    if (lex_len_q != '1) lex_len_q++;
                    pos_q = here + 1;
                    done = 1'b1;
                end else begin
                    put_token(cts_pkg::KIND_NUMBER, lex_start_q, lex_len_q);
                end
            end
            MODE_EQ, MODE_BANG, MODE_LT, MODE_GT: begin
                // A trailing '=' makes the pair; anything else closes the lone operator.
                if (c == cts_pkg::CH_EQ) begin
                    case (mode_q)
                        MODE_EQ:   kind = cts_pkg::KIND_EQ;
                        MODE_BANG: kind = cts_pkg::KIND_NE;
                        MODE_LT:   kind = cts_pkg::KIND_LE;
                        default:   kind = cts_pkg::KIND_GE;
                    endcase
                    put_token(kind, lex_start_q, 16'd2);
                    mode_q = MODE_IDLE;
                    kw_live_q = '1;
                    pos_q = here + 1;
                    done = 1'b1;
                end else begin
                    case (mode_q)
                        MODE_EQ:   kind = cts_pkg::KIND_ASSIGN;
                        MODE_BANG: kind = cts_pkg::KIND_UNKNOWN;
                        MODE_LT:   kind = cts_pkg::KIND_LT;
                        default:   kind = cts_pkg::KIND_GT;
                    endcase
                    put_token(kind, lex_start_q, 16'd1);
                end
            end
            default: ;
        endcase
        if (!done) begin
            mode_q = MODE_IDLE;
            kw_live_q = '1;
            if (c == cts_pkg::CH_NUL) begin
                put_token(cts_pkg::KIND_EOF, here, 16'd0);
                pos_q = '0;
            end else begin
                if (white(c)) begin
                end else if (ident_head(c)) begin
                    mode_q = MODE_IDENT;
                    lex_start_q = here;
                    lex_len_q = 16'd1;
                    kw_live_q = narrow_keywords('1, 16'd0, c);
                end else if (decimal(c)) begin
                    mode_q = MODE_NUMBER;
                    lex_start_q = here;
                    lex_len_q = 16'd1;
                end else if (c == cts_pkg::CH_EQ || c == cts_pkg::CH_BANG ||
                             c == cts_pkg::CH_LT || c == cts_pkg::CH_GT) begin
                    mode_q = (c == cts_pkg::CH_EQ)   ? MODE_EQ   :
                             (c == cts_pkg::CH_BANG) ? MODE_BANG :
                             (c == cts_pkg::CH_LT)   ? MODE_LT   : MODE_GT;
                    lex_start_q = here;
                    lex_len_q = 16'd1;
                end else begin
                    case (c)
                        "(":     kind = cts_pkg::KIND_LPAREN;
                        ")":     kind = cts_pkg::KIND_RPAREN;
                        "{":     kind = cts_pkg::KIND_LBRACE;
                        "}":     kind = cts_pkg::KIND_RBRACE;
                        ";":     kind = cts_pkg::KIND_SEMI;
                        ",":     kind = cts_pkg::KIND_COMMA;
                        "+":     kind = cts_pkg::KIND_PLUS;
                        "-":     kind = cts_pkg::KIND_MINUS;
                        "*":     kind = cts_pkg::KIND_STAR;
                        "/":     kind = cts_pkg::KIND_SLASH;
                        default: kind = cts_pkg::KIND_UNKNOWN;
                    endcase
                    put_token(kind, here, 16'd1);
                end
                pos_q = here + 1;
            end
        end
        if (scan_out.size() > 0) begin
            tail = scan_out.pop_back();
            tail.last = 1'b1;
            scan_out.push_back(tail);
        end
    endfunction

    function automatic logic [7:0] ident_char(input bit head);
        int r;
        r = head ? $urandom_range(0, 52) : $urandom_range(0, 62);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        if (r == 52) return cts_pkg::CH_US;
        return 8'("0" + r - 53);
    endfunction

    // Offers one word, waits for the handshake and records what it should produce.
    // The sender keeps tvalid up through a burst and drops it for a random gap after.
    task automatic send_byte(input logic [7:0] b, input logic typed,
                             input cts_pkg::t_token want);
        int gap;
        if (!valid_up) begin
            i_s_axis_tvalid <= 1'b1;
            valid_up = 1'b1;
        end
        i_s_axis_tdata <= b;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        bytes_sent++;
        scan_byte(b);
        if (typed) begin
            want.last = 1'b1;
            tokens_due.push_back(want);
        end else begin
            foreach (scan_out[i]) tokens_due.push_back(scan_out[i]);
        end
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            i_s_axis_tvalid <= 1'b0;
            valid_up = 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0, '0);
    endtask

    initial begin : stimulus
        int mark;
        int pick;
        int k;
        int len;
        bit hold_used;
        t_row row;
        hold_used = 1'b0;
        reset_scanner();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        burst_left = $urandom_range(1, 40);

        for (int i = 0; i < NUM_ROWS; i++) begin
            row = dir_rows[i];
            send_byte(row.ch, row.typed,
                      '{kind: row.kind, start: row.start, length: row.len, last: 1'b0});
        end

        // Random text: mostly well-formed lexemes, with some noise and stray ends of text.
        mark = bytes_sent;
        while (bytes_sent - mark < RANDOM_BYTES) begin
            if (!hold_used && bytes_sent - mark > RANDOM_BYTES / 2) begin
                hold_req = 1'b1;
                hold_used = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                k = $urandom_range(0, cts_pkg::NUM_KW - 1);
                case ($urandom_range(0, 3))
                    0: begin
                        for (int i = 0; i < cts_pkg::KW_SIZE[k]; i++) begin
                            send_byte(cts_pkg::KW_TEXT[k][i], 1'b0, '0);
                        end
                    end
                    1: begin
                        len = $urandom_range(1, cts_pkg::KW_SIZE[k] - 1);
                        for (int i = 0; i < len; i++) begin
                            send_byte(cts_pkg::KW_TEXT[k][i], 1'b0, '0);
                        end
                    end
                    2: begin
                        for (int i = 0; i < cts_pkg::KW_SIZE[k]; i++) begin
                            send_byte(cts_pkg::KW_TEXT[k][i], 1'b0, '0);
                        end
                        send_byte(ident_char(1'b0), 1'b0, '0);
                    end
                    default: begin
                        len = $urandom_range(1, 10);
                        send_byte(ident_char(1'b1), 1'b0, '0);
                        for (int i = 1; i < len; i++) send_byte(ident_char(1'b0), 1'b0, '0);
                    end
                endcase
                if ($urandom_range(0, 1)) send_byte(" ", 1'b0, '0);
            end else if (pick < 60) begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) send_byte(8'("0" + $urandom_range(0, 9)), 1'b0, '0);
            end else if (pick < 80) begin
                send_text(op_text[$urandom_range(0, 17)]);
            end else if (pick < 92) begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++) begin
                    k = $urandom_range(8, 13);
                    send_byte((k == 8) ? 8'd32 : 8'(k), 1'b0, '0);
                end
            end else if (pick < 97) begin
                send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
            end else begin
                send_byte(cts_pkg::CH_NUL, 1'b0, '0);
            end
        end
        send_byte(cts_pkg::CH_NUL, 1'b0, '0);
        if (valid_up) begin
            i_s_axis_tvalid <= 1'b0;
            valid_up = 1'b0;
        end

        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        k = 0;
        for (int i = 0; i <= 32; i++) if (kinds_seen[i]) k++;
        $display("Scanned %0d bytes and checked %0d tokens covering %0d of 33 token kinds.",
                 bytes_sent, tokens_checked, k);
        $display("Longest lexeme seen: %0d bytes; output held off once for %0d cycles.",
                 longest_lexeme, HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Receiver: changes its stall pattern every so often, and holds off once on request.
    initial begin : receiver
        int stall_mode;
        int phase_left;
        int tick;
        stall_mode = 0;
        phase_left = 0;
        tick = 0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_req) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (phase_left == 0) begin
                    stall_mode = $urandom_range(0, 2);
                    phase_left = $urandom_range(20, 200);
                end
                phase_left--;
                case (stall_mode)
                    0:       i_m_axis_tready <= 1'b1;
                    1:       i_m_axis_tready <= 1'($urandom_range(0, 1));
                    default: i_m_axis_tready <= (tick % 4 == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : token_check
        cts_pkg::t_token want;
        logic [5:0]      kind;
        logic [31:0]     start;
        logic [15:0]     len;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            kind  = o_m_axis_tdata[5:0];
            start = o_m_axis_tdata[37:6];
            len   = o_m_axis_tdata[53:38];
            tokens_checked++;
            if (kind <= cts_pkg::KIND_UNKNOWN) kinds_seen[kind] = 1'b1;
            if (int'(len) > longest_lexeme) longest_lexeme = int'(len);
            if (tokens_due.size() == 0) begin
                $error("token with nothing expected: kind %0d start %0d length %0d",
                       kind, start, len);
                fail_count++;
            end else begin
                want = tokens_due.pop_front();
                if (kind !== want.kind) begin
                    $error("token_kind mismatch: expected %0d, got %0d", want.kind, kind);
                    fail_count++;
                end
                if (start !== want.start) begin
                    $error("token_start mismatch: expected %0d, got %0d", want.start, start);
                    fail_count++;
                end
                if (len !== want.length) begin
                    $error("token_length mismatch: expected %0d, got %0d", want.length, len);
                    fail_count++;
                end
                if (o_m_axis_tlast !== want.last) begin
                    $error("last_of_run mismatch: expected %0d, got %0d",
                           want.last, o_m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
